@@ src/qxrm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package qxrm_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;
    localparam int Q              = 30;

    typedef logic signed [31:0] q30_t;
    typedef logic signed [63:0] q60_t;

    // Taylor coefficients, Q30, lowest order first
    localparam logic [31:0] SIN_COEF [7] = '{
        32'd1686629713, 32'd693598668, 32'd85569306, 32'd5026995,
        32'd172272, 32'd3864, 32'd61
    };
    localparam logic [31:0] COS_COEF [7] = '{
        32'd1324675879, 32'd272375560, 32'd22401992, 32'd987048,
        32'd27060, 32'd506, 32'd7
    };

    // Q30 by Q30 product, rounded half away from zero back to Q30
    function automatic q30_t qmul(input q30_t a, input q30_t b);
        logic signed [63:0] p;
        logic [63:0] m;
        begin
            p = 64'(a) * 64'(b);
            if (p < 0)
            begin
                m = ((64'd0 - 64'(p)) + (64'd1 << (Q - 1))) >> Q;
                qmul = -q30_t'(m[31:0]);
            end
            else
            begin
                m = (64'(p) + (64'd1 << (Q - 1))) >> Q;
                qmul = q30_t'(m[31:0]);
            end
        end
    endfunction

endpackage
`default_nettype wire

@@ src/qxrm_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface qxrm_in_if;
    logic valid;
    logic ready;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    modport source (output valid, output angle_x, output angle_y, output angle_z, input ready);
    modport sink (input valid, input angle_x, input angle_y, input angle_z, output ready);
endinterface

interface qxrm_out_if;
    logic valid;
    logic ready;
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
    modport source (output valid, output r00, output r01, output r02, output r10,
                    output r11, output r12, output r20, output r21, output r22,
                    input ready);
    modport sink (input valid, input r00, input r01, input r02, input r10,
                  input r11, input r12, input r20, input r21, input r22,
                  output ready);
endinterface
`default_nettype wire

@@ src/qxrm_sincos.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Half-angle sine and cosine: one Horner step per stage, 8 stages
module qxrm_sincos #(
    parameter int ANGLE_BITS = qxrm_pkg::ANGLE_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic [15:0]         angle,
    output qxrm_pkg::q30_t           s,
    output qxrm_pkg::q30_t           c
);
    localparam int NST = 7;

    qxrm_pkg::q30_t t_reg  [NST];
    qxrm_pkg::q30_t u_reg  [NST];
    qxrm_pkg::q30_t as_reg [NST];
    qxrm_pkg::q30_t ac_reg [NST];
    qxrm_pkg::q30_t t0_next;
    qxrm_pkg::q30_t s_reg;
    qxrm_pkg::q30_t c_reg;
    logic signed [ANGLE_BITS-1:0] a_lo;
    logic signed [32:0] t_wide;

    // Scale the binary angle to a Q30 fraction of a quarter turn
    always_comb
    begin
        a_lo = $signed(ANGLE_BITS'({{(ANGLE_BITS > 16 ? ANGLE_BITS - 16 : 1){angle[15]}},
                                    angle}));
        if (ANGLE_BITS <= 31)
        begin
            t_wide = 33'(a_lo) <<< (ANGLE_BITS <= 31 ? 31 - ANGLE_BITS : 0);
        end
        else
        begin
            t_wide = (33'(a_lo) - 33'(a_lo[0])) >>> 1;
        end
        t0_next = qxrm_pkg::q30_t'(t_wide[31:0]);
    end

    // Stage 0 forms u; stages 1..6 run Horner; stage 7 finishes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[0]  <= t0_next;
            u_reg[0]  <= qxrm_pkg::qmul(t0_next, t0_next);
            as_reg[0] <= $signed(qxrm_pkg::SIN_COEF[6]);
            ac_reg[0] <= $signed(qxrm_pkg::COS_COEF[6]);
            for (int k = 1; k < NST; k++)
            begin
                t_reg[k]  <= t_reg[k-1];
                u_reg[k]  <= u_reg[k-1];
                as_reg[k] <= $signed(qxrm_pkg::SIN_COEF[6-k])
                             - qxrm_pkg::qmul(u_reg[k-1], as_reg[k-1]);
                ac_reg[k] <= $signed(qxrm_pkg::COS_COEF[6-k])
                             - qxrm_pkg::qmul(u_reg[k-1], ac_reg[k-1]);
            end
            s_reg <= qxrm_pkg::qmul(t_reg[6], as_reg[6]);
            c_reg <= (32'sd1 <<< qxrm_pkg::Q) - qxrm_pkg::qmul(u_reg[6], ac_reg[6]);
        end
    end

    assign s = s_reg;
    assign c = c_reg;
endmodule
`default_nettype wire

@@ src/qxrm_divide.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Signed quotient num/den to FRAC_BITS fraction bits, one quotient bit per stage
module qxrm_divide #(
    parameter int FRAC_BITS = qxrm_pkg::FRAC_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic signed [63:0] num,
    input  wire logic [63:0]       den,
    output logic [15:0]            res
);
    localparam int NB = FRAC_BITS + 2;
    localparam int QW = FRAC_BITS + 3;

    logic [64:0]   rem_reg [NB];
    logic [QW-1:0] quo_reg [NB];
    logic [63:0]   den_reg [NB];
    logic          neg_reg [NB];
    logic          zero_reg[NB];
    logic [15:0]   res_reg;
    logic [63:0]   mag;
    logic [QW-1:0] rq;
    logic signed [QW:0] sr;

    assign mag = num[63] ? (64'd0 - 64'(num)) : 64'(num);

    // First stage takes the integer bit, the rest one fraction bit each
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0]  <= den;
            neg_reg[0]  <= num[63];
            zero_reg[0] <= (den == 64'd0);
            if (mag >= den)
            begin
                rem_reg[0] <= 65'(mag - den);
                quo_reg[0] <= QW'(1);
            end
            else
            begin
                rem_reg[0] <= 65'(mag);
                quo_reg[0] <= '0;
            end
            for (int i = 1; i < NB; i++)
            begin
                den_reg[i]  <= den_reg[i-1];
                neg_reg[i]  <= neg_reg[i-1];
                zero_reg[i] <= zero_reg[i-1];
                if ((rem_reg[i-1] << 1) >= 65'(den_reg[i-1]))
                begin
                    rem_reg[i] <= (rem_reg[i-1] << 1) - 65'(den_reg[i-1]);
                    quo_reg[i] <= (quo_reg[i-1] << 1) | QW'(1);
                end
                else
                begin
                    rem_reg[i] <= rem_reg[i-1] << 1;
                    quo_reg[i] <= quo_reg[i-1] << 1;
                end
            end
            res_reg <= sr[15:0];
        end
    end

    // Round half away from zero, clamp, restore sign; a zero divisor gives zero
    always_comb
    begin
        rq = (quo_reg[NB-1] + QW'(1)) >> 1;
        if (rq > (QW'(1) << FRAC_BITS))
        begin
            rq = QW'(1) << FRAC_BITS;
        end
        sr = neg_reg[NB-1] ? -$signed({1'b0, rq}) : $signed({1'b0, rq});
        if (zero_reg[NB-1])
        begin
            sr = '0;
        end
    end

    assign res = res_reg;
endmodule
`default_nettype wire

@@ src/quaternion_xyz_rotation_matrix_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Rotation matrix from three binary angles (65536 units per turn) via the
// product of per-axis half-angle quaternions, normalized, as Q2.14 elements.
// Fully pipelined: one angle triple per cycle while the output is not stalled,
// through the sine/cosine stages, then pair products, triple products, sums, squares
// and numerators, then one quotient bit per stage in the nine parallel dividers and
// the output register. The whole pipe advances when the output register is empty or
// being taken; a stall holds every stage.
module quaternion_xyz_rotation_matrix_core #(
    parameter int ANGLE_BITS = qxrm_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = qxrm_pkg::FRAC_BITS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    qxrm_in_if.sink   in_ch,
    qxrm_out_if.source out_ch
);
    localparam int LAT = 8 + 5 + FRAC_BITS + 3;

    logic           en;
    logic [LAT-1:0] vld_reg;
    qxrm_pkg::q30_t sx, cx, sy, cy, sz, cz;
    qxrm_pkg::q30_t p_reg [8];
    qxrm_pkg::q30_t sz1_reg, cz1_reg;
    qxrm_pkg::q30_t t_reg [8];
    qxrm_pkg::q30_t w_reg, x_reg, y_reg, z_reg;
    qxrm_pkg::q60_t sq_reg [10];
    qxrm_pkg::q60_t num_reg [9];
    logic [63:0]    n_reg;
    logic [15:0]    res [9];

    // Advance when the output is free or its transfer completes
    assign en = !vld_reg[LAT-1] || out_ch.ready;
    assign in_ch.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_ch.valid};
        end
    end

    qxrm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_scx (.clk(clk), .en(en),
        .angle(in_ch.angle_x), .s(sx), .c(cx));
    qxrm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_scy (.clk(clk), .en(en),
        .angle(in_ch.angle_y), .s(sy), .c(cy));
    qxrm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_scz (.clk(clk), .en(en),
        .angle(in_ch.angle_z), .s(sz), .c(cz));

    // Quaternion product: pair products, triple products, sums, squares, numerators and squared norm
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= qxrm_pkg::qmul(cx, cy);
            p_reg[1] <= qxrm_pkg::qmul(sx, sy);
            p_reg[2] <= qxrm_pkg::qmul(sx, cy);
            p_reg[3] <= qxrm_pkg::qmul(cx, sy);
            sz1_reg <= sz; cz1_reg <= cz;
            t_reg[0] <= qxrm_pkg::qmul(p_reg[0], cz1_reg);
            t_reg[1] <= qxrm_pkg::qmul(p_reg[1], sz1_reg);
            t_reg[2] <= qxrm_pkg::qmul(p_reg[2], cz1_reg);
            t_reg[3] <= qxrm_pkg::qmul(p_reg[3], sz1_reg);
            t_reg[4] <= qxrm_pkg::qmul(p_reg[3], cz1_reg);
            t_reg[5] <= qxrm_pkg::qmul(p_reg[2], sz1_reg);
            t_reg[6] <= qxrm_pkg::qmul(p_reg[0], sz1_reg);
            t_reg[7] <= qxrm_pkg::qmul(p_reg[1], cz1_reg);
            w_reg <= t_reg[0] - t_reg[1];
            x_reg <= t_reg[2] + t_reg[3];
            y_reg <= t_reg[4] - t_reg[5];
            z_reg <= t_reg[6] + t_reg[7];
            sq_reg[0] <= 64'(w_reg) * 64'(w_reg);
            sq_reg[1] <= 64'(x_reg) * 64'(x_reg);
            sq_reg[2] <= 64'(y_reg) * 64'(y_reg);
            sq_reg[3] <= 64'(z_reg) * 64'(z_reg);
            sq_reg[4] <= 64'(x_reg) * 64'(y_reg);
            sq_reg[5] <= 64'(w_reg) * 64'(z_reg);
            sq_reg[6] <= 64'(x_reg) * 64'(z_reg);
            sq_reg[7] <= 64'(w_reg) * 64'(y_reg);
            sq_reg[8] <= 64'(y_reg) * 64'(z_reg);
            sq_reg[9] <= 64'(w_reg) * 64'(x_reg);
            n_reg <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]) + 64'(sq_reg[3]);
            num_reg[0] <= sq_reg[0] + sq_reg[1] - sq_reg[2] - sq_reg[3];
            num_reg[1] <= (sq_reg[4] - sq_reg[5]) <<< 1;
            num_reg[2] <= (sq_reg[6] + sq_reg[7]) <<< 1;
            num_reg[3] <= (sq_reg[4] + sq_reg[5]) <<< 1;
            num_reg[4] <= sq_reg[0] - sq_reg[1] + sq_reg[2] - sq_reg[3];
            num_reg[5] <= (sq_reg[8] - sq_reg[9]) <<< 1;
            num_reg[6] <= (sq_reg[6] - sq_reg[7]) <<< 1;
            num_reg[7] <= (sq_reg[8] + sq_reg[9]) <<< 1;
            num_reg[8] <= sq_reg[0] - sq_reg[1] - sq_reg[2] + sq_reg[3];
        end
    end

    for (genvar g = 0; g < 9; g++)
    begin : g_div
        qxrm_divide #(.FRAC_BITS(FRAC_BITS)) u_div (.clk(clk), .en(en),
            .num(num_reg[g]), .den(n_reg), .res(res[g]));
    end

    assign out_ch.valid = vld_reg[LAT-1];
    assign out_ch.r00 = res[0];
    assign out_ch.r01 = res[1];
    assign out_ch.r02 = res[2];
    assign out_ch.r10 = res[3];
    assign out_ch.r11 = res[4];
    assign out_ch.r12 = res[5];
    assign out_ch.r20 = res[6];
    assign out_ch.r21 = res[7];
    assign out_ch.r22 = res[8];
endmodule
`default_nettype wire

@@ dv/qxrm_tb_if.sv @@
`timescale 1ns / 1ps
// Handshake channels live in the RTL interface file; this file holds the
// transfer record shared by the bench.
package qxrm_tb_pkg;
    typedef struct packed {
        logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    } matrix_t;
endpackage

@@ dv/tb.sv @@
`timescale 1ns / 1ps
module tb;
    typedef qxrm_tb_pkg::matrix_t matrix_t;

    localparam int ANGLE_BITS = qxrm_pkg::ANGLE_BITS_DEF;
    localparam int FRAC_BITS  = qxrm_pkg::FRAC_BITS_DEF;
    localparam int N_RANDOM   = 1950;
    localparam int N_DIRECTED = 14;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    qxrm_in_if  in_ch ();
    qxrm_out_if out_ch ();

    quaternion_xyz_rotation_matrix_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always #6 clk = ~clk;

    matrix_t pending_matrices[$];
    int      mismatch_count = 0;
    int      sent_count = 0;
    bit      hold_off = 1'b0;
    bit      sender_done = 1'b0;

    localparam longint SIN_C [7] = '{1686629713, 693598668, 85569306, 5026995,
                                     172272, 3864, 61};
    localparam longint COS_C [7] = '{1324675879, 272375560, 22401992, 987048,
                                     27060, 506, 7};

    // Q30 product, rounded half away from zero
    function automatic longint mul_q30(longint a, longint b);
        longint p;
        begin
            p = a * b;
            if (p < 0)
                mul_q30 = -((-p + (64'sd1 <<< 29)) >>> 30);
            else
                mul_q30 = (p + (64'sd1 <<< 29)) >>> 30;
        end
    endfunction

    // half-angle sine and cosine in Q30
    function automatic void half_sin_cos(input logic [15:0] raw, output longint s,
                                         output longint c);
        longint t, u, as_acc, ac_acc;
        logic signed [ANGLE_BITS-1:0] a;
        begin
            a = raw[ANGLE_BITS-1:0];
            t = longint'(a) <<< (31 - ANGLE_BITS);
            u = mul_q30(t, t);
            as_acc = SIN_C[6];
            ac_acc = COS_C[6];
            for (int k = 5; k >= 0; k--)
            begin
                as_acc = SIN_C[k] - mul_q30(u, as_acc);
                ac_acc = COS_C[k] - mul_q30(u, ac_acc);
            end
            s = mul_q30(t, as_acc);
            c = (64'sd1 <<< 30) - mul_q30(u, ac_acc);
        end
    endfunction

    // rounded quotient of a Q60 numerator by the squared norm
    function automatic logic [15:0] matrix_element(longint num, logic [63:0] den);
        logic [63:0] mag, quo, rem;
        longint r;
        begin
            mag = num < 0 ? 64'(-num) : 64'(num);
            quo = mag >= den ? 64'd1 : 64'd0;
            rem = mag - quo * den;
            for (int i = 0; i <= FRAC_BITS; i++)
            begin
                rem = rem << 1;
                quo = quo << 1;
                if (rem >= den)
                begin
                    rem = rem - den;
                    quo[0] = 1'b1;
                end
            end
            quo = (quo + 64'd1) >> 1;
            if (quo > (64'd1 << FRAC_BITS))
                quo = 64'd1 << FRAC_BITS;
            r = num < 0 ? -longint'(quo) : longint'(quo);
            matrix_element = r[15:0];
        end
    endfunction

    function automatic matrix_t rotation_of(logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
        longint sx, cx, sy, cy, sz, cz, w, x, y, z, ww, xx, yy, zz;
        logic [63:0] n;
        matrix_t m;
        begin
            half_sin_cos(ax, sx, cx);
            half_sin_cos(ay, sy, cy);
            half_sin_cos(az, sz, cz);
            w = mul_q30(mul_q30(cx, cy), cz) - mul_q30(mul_q30(sx, sy), sz);
            x = mul_q30(mul_q30(sx, cy), cz) + mul_q30(mul_q30(cx, sy), sz);
            y = mul_q30(mul_q30(cx, sy), cz) - mul_q30(mul_q30(sx, cy), sz);
            z = mul_q30(mul_q30(cx, cy), sz) + mul_q30(mul_q30(sx, sy), cz);
            ww = w * w; xx = x * x; yy = y * y; zz = z * z;
            n = 64'(ww) + 64'(xx) + 64'(yy) + 64'(zz);
            if (n == 0)
            begin
                m = '0;
                m.r00 = 16'sd16384; m.r11 = 16'sd16384; m.r22 = 16'sd16384;
            end
            else
            begin
                m.r00 = matrix_element(ww + xx - yy - zz, n);
                m.r01 = matrix_element(2 * (x * y - w * z), n);
                m.r02 = matrix_element(2 * (x * z + w * y), n);
                m.r10 = matrix_element(2 * (x * y + w * z), n);
                m.r11 = matrix_element(ww - xx + yy - zz, n);
                m.r12 = matrix_element(2 * (y * z - w * x), n);
                m.r20 = matrix_element(2 * (x * z - w * y), n);
                m.r21 = matrix_element(2 * (y * z + w * x), n);
                m.r22 = matrix_element(ww - xx - yy + zz, n);
            end
            rotation_of = m;
        end
    endfunction

    // directed table: angles, whether an expected matrix is typed in, and that matrix
    typedef struct {
        logic [15:0] ax, ay, az;
        bit          typed;
        matrix_t     m;
    } pose_row_t;

    localparam logic signed [15:0] P1 = 16'sd16384;
    localparam logic signed [15:0] M1 = -16'sd16384;
    localparam logic signed [15:0] Z0 = 16'sd0;

    pose_row_t pose_table [N_DIRECTED];
    initial
    begin
        pose_table[0]  = '{16'h0000, 16'h0000, 16'h0000, 1'b1, '{P1,Z0,Z0, Z0,P1,Z0, Z0,Z0,P1}};
        // half turn about each axis
        pose_table[1]  = '{16'h8000, 16'h0000, 16'h0000, 1'b1, '{P1,Z0,Z0, Z0,M1,Z0, Z0,Z0,M1}};
        pose_table[2]  = '{16'h0000, 16'h8000, 16'h0000, 1'b1, '{M1,Z0,Z0, Z0,P1,Z0, Z0,Z0,M1}};
        pose_table[3]  = '{16'h0000, 16'h0000, 16'h8000, 1'b1, '{M1,Z0,Z0, Z0,M1,Z0, Z0,Z0,P1}};
        pose_table[4]  = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, '0};
        pose_table[5]  = '{16'h8000, 16'h8000, 16'h8000, 1'b0, '0};
        pose_table[6]  = '{16'hFFFF, 16'h0001, 16'hFFFF, 1'b0, '0};
        pose_table[7]  = '{16'h4000, 16'h0000, 16'h0000, 1'b0, '0};
        pose_table[8]  = '{16'h0000, 16'h4000, 16'h0000, 1'b0, '0};
        pose_table[9]  = '{16'h0000, 16'h0000, 16'hC000, 1'b0, '0};
        pose_table[10] = '{16'h4000, 16'h4000, 16'h4000, 1'b0, '0};
        pose_table[11] = '{16'h2000, 16'hE000, 16'h6000, 1'b0, '0};
        pose_table[12] = '{16'h5555, 16'hAAAA, 16'h0F0F, 1'b0, '0};
        pose_table[13] = '{16'hF0F0, 16'h3333, 16'hCCCC, 1'b0, '0};
    end

    // offer one pose and wait for its transfer
    task automatic send_pose(input logic [15:0] ax, input logic [15:0] ay,
                             input logic [15:0] az, input matrix_t m);
        int gap;
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_ch.valid   <= 1'b1;
            in_ch.angle_x <= ax;
            in_ch.angle_y <= ay;
            in_ch.angle_z <= az;
            @(posedge clk);
            while (!in_ch.ready) @(posedge clk);
            pending_matrices = {pending_matrices, m};
            sent_count++;
            @(negedge clk);
        end
    endtask

    // sender
    initial
    begin
        logic [15:0] ax, ay, az;
        in_ch.valid   = 1'b0;
        in_ch.angle_x = '0;
        in_ch.angle_y = '0;
        in_ch.angle_z = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        for (int i = 0; i < N_DIRECTED; i++)
            send_pose(pose_table[i].ax, pose_table[i].ay, pose_table[i].az,
                      pose_table[i].typed ? pose_table[i].m
                      : rotation_of(pose_table[i].ax, pose_table[i].ay, pose_table[i].az));
        for (int i = 0; i < N_RANDOM; i++)
        begin
            ax = 16'($urandom);
            ay = 16'($urandom);
            az = 16'($urandom);
            // bias some items to small angles and exact quarter turns
            if ($urandom_range(0, 7) == 0) ax = 16'($signed($urandom_range(0, 64)) - 32);
            if ($urandom_range(0, 7) == 0) az = {2'($urandom), 14'd0};
            send_pose(ax, ay, az, rotation_of(ax, ay, az));
        end
        in_ch.valid <= 1'b0;
        sender_done = 1'b1;
    end

    // long receiver hold-off once the random part is underway
    initial
    begin
        wait (sent_count == N_DIRECTED + 200);
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
    end

    // receiver ready pattern
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            @(negedge clk);
            if (stall > 0 || hold_off)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
                while (hold_off) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
        end
    end

    // check each output transfer against the oldest expectation
    always @(posedge clk)
    begin
        matrix_t got, want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = '{out_ch.r00, out_ch.r01, out_ch.r02, out_ch.r10, out_ch.r11,
                    out_ch.r12, out_ch.r20, out_ch.r21, out_ch.r22};
            if (pending_matrices.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected output matrix %h", got);
            end
            else
            begin
                want = pending_matrices.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("matrix mismatch: expected %h actual %h", want, got);
                end
            end
        end
    end

    // drain and report
    initial
    begin
        wait (sender_done);
        wait (pending_matrices.size() == 0);
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && pending_matrices.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

@@ sim.f @@
src/qxrm_pkg.sv
src/qxrm_if.sv
src/qxrm_sincos.sv
src/qxrm_divide.sv
src/quaternion_xyz_rotation_matrix_core.sv
dv/qxrm_tb_if.sv
dv/tb.sv
